// File: src/string_to_unsigned_integer_unit_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef STRING_TO_UNSIGNED_INTEGER_UNIT_MACROS_SVH
`define STRING_TO_UNSIGNED_INTEGER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define STOU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define STOU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/stou_pkg.sv
`default_nettype none

package stou_pkg;

  localparam int MaxChars  = 4096;
  localparam int OffsetCap = ((MaxChars - 1) < 4095) ? (MaxChars - 1) : 4095;
  localparam int PosW      = 12;
  localparam logic [PosW-1:0] OffsetCapW = PosW'(OffsetCap);

  // register map, word index
  localparam logic RegRadix = 1'b0;
  localparam logic [5:0] RadixReset = 6'd10;
  localparam logic [5:0] RadixAuto  = 6'd0;
  localparam logic [5:0] RadixMax   = 6'd36;
  localparam logic [5:0] RadixOct   = 6'd8;
  localparam logic [5:0] RadixDec   = 6'd10;
  localparam logic [5:0] RadixHex   = 6'd16;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoX   = 8'h78;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] UpperBias = ChUpA - 8'd10;
  localparam logic [7:0] LowerBias = ChLoA - 8'd10;
  localparam logic [6:0] DigitNone = 7'd99;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS,
    PH_DONE,
    PH_IDLE
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [63:0]     accumulator;
    logic [5:0]      eff_radix;
    logic            negative;
    logic            overflowed;
    logic            digit_seen;
    logic [PosW-1:0] position;
    logic [PosW-1:0] stop_at;
    logic            latched;
    logic [5:0]      base_latch;
  } parse_state_t;

  typedef struct packed {
    logic            bad_radix;
    logic            no_digits;
    logic            overflow;
    logic [PosW-1:0] end_offset;
    logic [63:0]     value;
  } result_t;

  localparam parse_state_t StateReset = '{
    phase:       PH_SPACE,
    accumulator: 64'd0,
    eff_radix:   6'd0,
    negative:    1'b0,
    overflowed:  1'b0,
    digit_seen:  1'b0,
    position:    '0,
    stop_at:     '0,
    latched:     1'b0,
    base_latch:  6'd0
  };

  function automatic logic radix_bad(input logic [5:0] r);
    return (r == 6'd1) || (r > RadixMax);
  endfunction

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(DigitNone);
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = c - UpperBias;
    end else if (c >= ChLoA && c <= ChLoZ) begin
      d = c - LowerBias;
    end
    return d[6:0];
  endfunction

  function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] p);
    return (p < OffsetCapW) ? p + 1'b1 : OffsetCapW;
  endfunction

endpackage

`default_nettype wire

// File: src/string_to_unsigned_integer_unit.sv
// String to unsigned 64-bit integer converter. Characters stream in one per
// cycle on the slave side (tuser marks the first character of a string, tlast
// the final one; a NUL also ends it). Each string gives one result on the
// master side: value, end offset and the overflow, no-digit and bad-radix
// flags. Throughput is one character per cycle; the only stall is a string
// end while the result register still holds an untaken result. From the last
// character to its result the path runs through an input register, then the
// per-character step whose 64x6 multiply-add sets the cycle time, then the
// result register. The radix register (APB, offset 0) is sampled at the first
// character of each string.
`default_nettype none

`include "string_to_unsigned_integer_unit_macros.svh"

module string_to_unsigned_integer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // character stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  wire logic        s_axis_tuser,   // [0] first
  input  wire logic        s_axis_tlast,   // last
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [63:0] value, [75:64] end_offset, [76] overflow, [77] no_digits,
  // [78] bad_radix, [79] zero
  output logic      [79:0] m_axis_tdata
);
  import stou_pkg::*;

  logic [5:0]   radix;
  logic         s1_valid_q, s1_valid_d;
  logic [7:0]   s1_ch_q;
  logic         s1_first_q;
  logic         s1_last_q;
  parse_state_t state_q, state_d, step_state;
  logic         step_emit;
  result_t      step_res;
  result_t      res_q;
  logic         out_valid_q, out_valid_d;
  logic         out_free;
  logic         advance;
  logic         in_accept;
  logic         out_load;

  stou_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radix_o (radix)
  );

  stou_char_step u_step (
    .state_i  (state_q),
    .ch_i     (s1_ch_q),
    .first_i  (s1_first_q),
    .last_i   (s1_last_q),
    .radix_i  (radix),
    .state_o  (step_state),
    .emit_o   (step_emit),
    .result_o (step_res)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = s1_valid_q && (!step_emit || out_free);
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = advance && step_emit;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (advance) begin
      state_d = step_state;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ch_q    <= s_axis_tdata;
      s1_first_q <= s_axis_tuser;
      s1_last_q  <= s_axis_tlast;
    end
    if (out_load) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.bad_radix, res_q.no_digits, res_q.overflow,
                          res_q.end_offset, res_q.value};

  `STOU_ASSERT_IMP(a_load_free, out_load, out_free, "result register overwritten")
  `STOU_ASSERT_NXT(a_s1_hold, s1_valid_q && !advance, s1_valid_q,
                   "held character lost")
  `STOU_ASSERT_IMP(a_ovf_ones, m_axis_tvalid && res_q.overflow, res_q.value == '1,
                   "overflow result not all ones")
  `STOU_ASSERT_IMP(a_bad_zero, m_axis_tvalid && res_q.bad_radix,
                   res_q.no_digits && (res_q.value == 64'd0) && !res_q.overflow,
                   "bad radix result not cleared")

endmodule

`default_nettype wire

// File: src/stou_apb_regs.sv
`default_nettype none

module stou_apb_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [5:0]  radix_o
);
  import stou_pkg::*;

  logic [5:0] radix_q, radix_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == RegRadix);

  always_comb begin
    radix_d = radix_q;
    if (wr_en) begin
      radix_d = pwdata[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else begin
      radix_q <= radix_d;
    end
  end

  assign prdata  = (paddr[2] == RegRadix) ? {26'd0, radix_q} : 32'd0;
  assign radix_o = radix_q;

endmodule

`default_nettype wire

// File: src/stou_char_step.sv
`default_nettype none

// One character of the parse: next state and, at string end, the result.
module stou_char_step (
  input  wire stou_pkg::parse_state_t state_i,
  input  wire logic [7:0]             ch_i,
  input  wire logic                   first_i,
  input  wire logic                   last_i,
  input  wire logic [5:0]             radix_i,
  output stou_pkg::parse_state_t      state_o,
  output logic                        emit_o,
  output stou_pkg::result_t           result_o
);
  import stou_pkg::*;

  parse_state_t s, n;
  logic         sign_done;
  logic         do_take;
  logic         is_ws;
  logic         bad;
  logic [6:0]   digit;
  logic [69:0]  prod;

  assign digit = digit_of(ch_i);
  assign is_ws = (ch_i == ChSpace) || (ch_i >= ChTab && ch_i <= ChCr);

  always_comb begin
    s         = first_i ? StateReset : state_i;
    n         = s;
    emit_o    = 1'b0;
    sign_done = 1'b0;
    do_take   = 1'b0;
    prod      = '0;
    if (s.phase != PH_IDLE) begin
      if (!n.latched) begin
        n.latched    = 1'b1;
        n.base_latch = radix_i;
      end
      if (ch_i == ChNul) begin
        // NUL ends the string without being consumed
        emit_o  = 1'b1;
        n.phase = PH_IDLE;
      end else begin
        if (!radix_bad(n.base_latch)) begin
          case (s.phase)
            PH_SPACE: begin
              if (is_ws) begin
                n.phase = PH_SPACE;
              end else if (ch_i == ChMinus) begin
                n.negative = 1'b1;
                n.phase    = PH_SIGNED;
              end else if (ch_i == ChPlus) begin
                n.phase = PH_SIGNED;
              end else begin
                sign_done = 1'b1;
              end
            end
            PH_SIGNED: sign_done = 1'b1;
            PH_ZERO: begin
              if (ch_i == ChLoX || ch_i == ChUpX) begin
                n.eff_radix = RadixHex;
                n.phase     = PH_PREFIX;
              end else begin
                n.eff_radix = (n.base_latch == RadixAuto) ? RadixOct : RadixHex;
                do_take     = 1'b1;
              end
            end
            PH_PREFIX, PH_DIGITS: do_take = 1'b1;
            default: n.phase = s.phase;
          endcase
          if (sign_done) begin
            if ((n.base_latch == RadixAuto || n.base_latch == RadixHex) &&
                ch_i == ChZero) begin
              // leading zero may open a hex prefix
              n.accumulator = 64'd0;
              n.digit_seen  = 1'b1;
              n.stop_at     = next_pos(s.position);
              n.phase       = PH_ZERO;
            end else begin
              n.eff_radix = (n.base_latch == RadixAuto) ? RadixDec : n.base_latch;
              do_take     = 1'b1;
            end
          end
          if (do_take) begin
            prod = 70'(n.accumulator) * 70'(n.eff_radix) + 70'(digit);
            if (n.eff_radix < 6'd2 || digit >= {1'b0, n.eff_radix}) begin
              n.phase = PH_DONE;
            end else begin
              if (n.overflowed || (prod[69:64] != 6'd0)) begin
                n.overflowed = 1'b1;
              end else begin
                n.accumulator = prod[63:0];
              end
              n.digit_seen = 1'b1;
              n.stop_at    = next_pos(s.position);
              n.phase      = PH_DIGITS;
            end
          end
        end
        n.position = next_pos(s.position);
        if (last_i) begin
          emit_o  = 1'b1;
          n.phase = PH_IDLE;
        end
      end
    end
  end

  assign bad = radix_bad(n.base_latch) && n.latched;

  always_comb begin
    result_o           = '0;
    result_o.bad_radix = bad;
    result_o.no_digits = 1'b1;
    if (!bad && n.digit_seen) begin
      result_o.no_digits  = 1'b0;
      result_o.end_offset = n.stop_at;
      if (n.overflowed) begin
        result_o.value    = '1;
        result_o.overflow = 1'b1;
      end else begin
        result_o.value = n.negative ? (64'd0 - n.accumulator) : n.accumulator;
      end
    end
  end

  assign state_o = n;

endmodule

`default_nettype wire
